### design/sfa_pkg.sv
// Shared constants for the segregated-fit allocator.
// Field widths, configuration register indexes and operation codes.
// No dependencies.
package sfa_pkg;

    // Word field widths
    localparam int FUNC_W   = 1;
    localparam int BYTES_W  = 16;
    localparam int ADDR_W   = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int CMIN_W     = 13;
    localparam int SHIFT_W    = 4;
    localparam int LIMIT_W    = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_COALESCE_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_SHIFT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT   = 2'd2;

    localparam logic [CMIN_W-1:0]  CMIN_RESET  = 13'd50;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd3;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

    // Request size in units is 13 bits wide (64 KiB / 16 plus header)
    localparam int REQ_W = 13;
    // Unit number carried by a free address
    localparam int TGT_W = 12;

endpackage

### design/sfa_if.sv
// Handshake channels of the segregated-fit allocator: request and result.
// Depends on sfa_pkg for the field widths.
interface sfa_req_if;
    logic                        valid;
    logic                        ready;
    logic [sfa_pkg::FUNC_W-1:0]  func;
    logic [sfa_pkg::BYTES_W-1:0] req_bytes;
    logic [sfa_pkg::ADDR_W-1:0]  free_addr;

    modport source (output valid, output func, output req_bytes, output free_addr,
                    input ready);
    modport sink   (input valid, input func, input req_bytes, input free_addr,
                    output ready);
endinterface

interface sfa_res_if;
    logic                       valid;
    logic                       ready;
    logic [sfa_pkg::ADDR_W-1:0] payload_addr;
    logic                       ok;
    logic                       merged;

    modport source (output valid, output payload_addr, output ok, output merged,
                    input ready);
    modport sink   (input valid, input payload_addr, input ok, input merged,
                    output ready);
endinterface

### design/segregated_fit_allocator.sv
// Segregated-fit heap allocator: top level with the sequencer and list heads.
// Depends on sfa_pkg, sfa_if and sfa_hdr_mem.
//
// One word is taken at a time; all block headers live in a single memory with
// one registered read port, and every list or heap step is one read followed
// by one check. An allocate walks the free-list nodes of its own class, and a
// merge pass before it visits every block below the heap end. A free walks
// every block lying below the freed one. The result is held in an output
// register, and a new word is taken as soon as the sequencer is idle again.
module segregated_fit_allocator #(
    parameter int HEAP_UNITS  = 4096,
    parameter int NUM_CLASSES = 14
) (
    input  logic                              clk,
    input  logic                              rst_n,
    sfa_req_if.sink                           req,
    sfa_res_if.source                         res,
    input  logic                              cfg_we,
    input  logic [sfa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sfa_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sfa_pkg::*;

    localparam int UW  = $clog2(HEAP_UNITS);
    localparam int SW  = UW + 1;
    localparam int PW  = SW + 1;
    localparam int CW  = (SW > REQ_W) ? SW : REQ_W;
    localparam int HW  = SW + UW + 2;
    localparam int CLW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_MRD    = 16'h0002,
        S_MCHK   = 16'h0004,
        S_MEND   = 16'h0008,
        S_FSTART = 16'h0010,
        S_WRD    = 16'h0020,
        S_WCHK   = 16'h0040,
        S_WFIN   = 16'h0080,
        S_HSEL   = 16'h0100,
        S_HCHK   = 16'h0200,
        S_HSPLIT = 16'h0400,
        S_GROW   = 16'h0800,
        S_FRD    = 16'h1000,
        S_FCHK   = 16'h2000,
        S_FFIN   = 16'h4000,
        S_DONE   = 16'h8000
    } state_t;

    // Header layout: size, allocated, next link, list end
    function automatic logic [HW-1:0] pack_hdr(input logic [SW-1:0] s, input logic a,
                                               input logic [UW-1:0] n, input logic e);
        return {s, a, n, e};
    endfunction

    // Size class: top set bit plus one, saturated
    function automatic logic [CLW-1:0] class_of(input logic [CW-1:0] n);
        int top;
        int c;
        top = 0;
        for (int i = 1; i < CW; i++)
        begin
            if (n[i])
            begin
                top = i;
            end
        end
        c = top + 1;
        if (c > NUM_CLASSES - 1)
        begin
            c = NUM_CLASSES - 1;
        end
        return CLW'(c);
    endfunction

    // Registers
    state_t             state_reg, state_next;
    logic [CMIN_W-1:0]  cmin_reg;
    logic [SHIFT_W-1:0] shift_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [UW-1:0]      heads_reg [NUM_CLASSES];
    logic [UW-1:0]      heads_next [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] valid_reg, valid_next;
    logic [SW-1:0]      heap_end_reg, heap_end_next;
    logic [SW-1:0]      total_reg, total_next;
    logic [SW-1:0]      free_reg, free_next;
    logic [CW-1:0]      rq_reg, rq_next;
    logic [CLW-1:0]     cls_reg, cls_next;
    logic [CLW-1:0]     hcls_reg, hcls_next;
    logic [PW-1:0]      u_reg, u_next;
    logic               open_reg, open_next;
    logic [UW-1:0]      run_reg, run_next;
    logic [SW-1:0]      run_size_reg, run_size_next;
    logic [UW-1:0]      cur_reg, cur_next;
    logic [HW-1:0]      prev_hdr_reg, prev_hdr_next;
    logic [UW-1:0]      prev_reg, prev_next;
    logic               has_prev_reg, has_prev_next;
    logic [SW-1:0]      guard_reg, guard_next;
    logic [HW-1:0]      hdr_reg, hdr_next;
    logic [UW-1:0]      got_reg, got_next;
    logic [TGT_W-1:0]   target_reg, target_next;
    logic               ok_reg, ok_next;
    logic               merged_reg, merged_next;
    logic               is_free_reg, is_free_next;
    logic               res_valid_reg, res_valid_next;
    logic [ADDR_W-1:0]  res_addr_reg, res_addr_next;
    logic               res_ok_reg, res_ok_next;
    logic               res_merged_reg, res_merged_next;

    // Memory port
    logic          mem_we;
    logic [UW-1:0] mem_waddr;
    logic [HW-1:0] mem_wdata;
    logic          mem_re;
    logic [UW-1:0] mem_raddr;
    logic [HW-1:0] mem_rdata;

    sfa_hdr_mem #(
        .DEPTH (HEAP_UNITS),
        .WIDTH (HW),
        .AW    (UW)
    ) u_hdr_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Fields of the header just read
    logic [SW-1:0] rd_size;
    logic          rd_alloc;
    logic [UW-1:0] rd_link;
    logic          rd_end;
    assign rd_size  = mem_rdata[HW-1 -: SW];
    assign rd_alloc = mem_rdata[UW+1];
    assign rd_link  = mem_rdata[UW:1];
    assign rd_end   = mem_rdata[0];

    // Request size in units and merge trigger
    logic [BYTES_W:0] bytes_round;
    logic [CW-1:0]    req_calc;
    logic             merge_hit;
    logic [SW+15:0]   free_shifted;
    assign bytes_round  = {1'b0, req.req_bytes} + (BYTES_W+1)'(15);
    assign req_calc     = CW'(bytes_round[BYTES_W:4]) + CW'(1);
    assign free_shifted = (SW+16)'(free_reg) << shift_reg;
    assign merge_hit    = (32'(total_reg) >= 32'(cmin_reg)) &&
                          (free_shifted >= (SW+16)'(total_reg));

    // Free address checks
    logic [TGT_W-1:0] tgt_calc;
    logic             free_bad;
    assign tgt_calc = req.free_addr[ADDR_W-1:4] - TGT_W'(1);
    assign free_bad = (req.free_addr[3:0] != 4'd0) || (req.free_addr < ADDR_W'(16)) ||
                      (32'(tgt_calc) >= 32'(heap_end_reg)) ||
                      (32'(tgt_calc) >= HEAP_UNITS);

    // Lowest non-empty class above the request class
    logic           hfound;
    logic [CLW-1:0] hidx;
    always_comb
    begin
        hfound = 1'b0;
        hidx   = '0;
        for (int i = NUM_CLASSES - 1; i >= 0; i--)
        begin
            if ((i > int'(cls_reg)) && valid_reg[i])
            begin
                hfound = 1'b1;
                hidx   = CLW'(i);
            end
        end
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign res.valid        = res_valid_reg;
    assign res.payload_addr = res_addr_reg;
    assign res.ok           = res_ok_reg;
    assign res.merged       = res_merged_reg;

    // Sequencer
    logic          push_en;
    logic [UW-1:0] push_unit;
    logic [SW-1:0] push_size;
    logic [CLW-1:0] pc;
    logic [31:0]   diff;
    logic [31:0]   nu;
    logic [31:0]   ne;
    logic [31:0]   pa;

    always_comb
    begin
        state_next      = state_reg;
        heads_next      = heads_reg;
        valid_next      = valid_reg;
        heap_end_next   = heap_end_reg;
        total_next      = total_reg;
        free_next       = free_reg;
        rq_next         = rq_reg;
        cls_next        = cls_reg;
        hcls_next       = hcls_reg;
        u_next          = u_reg;
        open_next       = open_reg;
        run_next        = run_reg;
        run_size_next   = run_size_reg;
        cur_next        = cur_reg;
        prev_hdr_next   = prev_hdr_reg;
        prev_next       = prev_reg;
        has_prev_next   = has_prev_reg;
        guard_next      = guard_reg;
        hdr_next        = hdr_reg;
        got_next        = got_reg;
        target_next     = target_reg;
        ok_next         = ok_reg;
        merged_next     = merged_reg;
        is_free_next    = is_free_reg;
        res_valid_next  = res_valid_reg;
        res_addr_next   = res_addr_reg;
        res_ok_next     = res_ok_reg;
        res_merged_next = res_merged_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        push_en         = 1'b0;
        push_unit       = '0;
        push_size       = '0;
        pc              = '0;
        diff            = '0;
        nu              = '0;
        ne              = '0;
        pa              = '0;

        // Result taken downstream
        if (res_valid_reg && res.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    ok_next     = 1'b0;
                    merged_next = 1'b0;
                    if (req.func == FUNC_ALLOC)
                    begin
                        is_free_next = 1'b0;
                        rq_next      = req_calc;
                        if (merge_hit)
                        begin
                            valid_next  = '0;
                            free_next   = '0;
                            u_next      = '0;
                            open_next   = 1'b0;
                            merged_next = 1'b1;
                            state_next  = S_MRD;
                        end
                        else
                        begin
                            state_next = S_FSTART;
                        end
                    end
                    else
                    begin
                        is_free_next = 1'b1;
                        target_next  = tgt_calc;
                        u_next       = '0;
                        state_next   = free_bad ? S_DONE : S_FRD;
                    end
                end
            end

            // Merge scan: read the block at u
            S_MRD:
            begin
                if ((32'(u_reg) < 32'(heap_end_reg)) && (32'(u_reg) < HEAP_UNITS))
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = u_reg[UW-1:0];
                    state_next = S_MCHK;
                end
                else
                begin
                    state_next = S_MEND;
                end
            end

            S_MCHK:
            begin
                if (rd_size == '0)
                begin
                    state_next = S_MEND;
                end
                else
                begin
                    if (rd_alloc)
                    begin
                        if (open_reg)
                        begin
                            push_en   = 1'b1;
                            push_unit = run_reg;
                            push_size = run_size_reg;
                        end
                        open_next = 1'b0;
                    end
                    else if (!open_reg)
                    begin
                        run_next      = u_reg[UW-1:0];
                        run_size_next = rd_size;
                        open_next     = 1'b1;
                    end
                    else
                    begin
                        run_size_next = run_size_reg + rd_size;
                        if (total_reg != '0)
                        begin
                            total_next = total_reg - SW'(1);
                        end
                    end
                    u_next     = u_reg + PW'(rd_size);
                    state_next = S_MRD;
                end
            end

            // Trailing run is pushed too
            S_MEND:
            begin
                if (open_reg)
                begin
                    push_en   = 1'b1;
                    push_unit = run_reg;
                    push_size = run_size_reg;
                end
                open_next  = 1'b0;
                state_next = S_FSTART;
            end

            S_FSTART:
            begin
                cls_next = class_of(rq_reg);
                if (valid_reg[class_of(rq_reg)])
                begin
                    cur_next      = heads_reg[class_of(rq_reg)];
                    has_prev_next = 1'b0;
                    guard_next    = '0;
                    state_next    = S_WRD;
                end
                else
                begin
                    state_next = S_HSEL;
                end
            end

            // First-fit walk of the own class
            S_WRD:
            begin
                if (32'(guard_reg) < HEAP_UNITS)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = cur_reg;
                    state_next = S_WCHK;
                end
                else
                begin
                    state_next = S_HSEL;
                end
            end

            S_WCHK:
            begin
                if (CW'(rd_size) >= rq_reg)
                begin
                    got_next = cur_reg;
                    ok_next  = 1'b1;
                    hdr_next = pack_hdr(rd_size, 1'b1, rd_link, 1'b0);
                    if (free_reg != '0)
                    begin
                        free_next = free_reg - SW'(1);
                    end
                    if (has_prev_reg)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = prev_reg;
                        mem_wdata  = pack_hdr(prev_hdr_reg[HW-1 -: SW], prev_hdr_reg[UW+1],
                                              rd_link, rd_end);
                        state_next = S_WFIN;
                    end
                    else
                    begin
                        if (rd_end)
                        begin
                            valid_next[cls_reg] = 1'b0;
                        end
                        else
                        begin
                            heads_next[cls_reg] = rd_link;
                        end
                        mem_we     = 1'b1;
                        mem_waddr  = cur_reg;
                        mem_wdata  = pack_hdr(rd_size, 1'b1, rd_link, 1'b0);
                        state_next = S_DONE;
                    end
                end
                else if (rd_end)
                begin
                    state_next = S_HSEL;
                end
                else
                begin
                    prev_next     = cur_reg;
                    prev_hdr_next = mem_rdata;
                    has_prev_next = 1'b1;
                    cur_next      = rd_link;
                    guard_next    = guard_reg + SW'(1);
                    state_next    = S_WRD;
                end
            end

            S_WFIN:
            begin
                mem_we     = 1'b1;
                mem_waddr  = got_reg;
                mem_wdata  = hdr_reg;
                state_next = S_DONE;
            end

            // Head of the next non-empty higher class
            S_HSEL:
            begin
                if (hfound)
                begin
                    hcls_next  = hidx;
                    cur_next   = heads_reg[hidx];
                    mem_re     = 1'b1;
                    mem_raddr  = heads_reg[hidx];
                    state_next = S_HCHK;
                end
                else
                begin
                    state_next = S_GROW;
                end
            end

            S_HCHK:
            begin
                if (CW'(rd_size) < rq_reg)
                begin
                    state_next = S_GROW;
                end
                else
                begin
                    if (rd_end)
                    begin
                        valid_next[hcls_reg] = 1'b0;
                    end
                    else
                    begin
                        heads_next[hcls_reg] = rd_link;
                    end
                    if (free_reg != '0)
                    begin
                        free_next = free_reg - SW'(1);
                    end
                    got_next  = cur_reg;
                    ok_next   = 1'b1;
                    mem_we    = 1'b1;
                    mem_waddr = cur_reg;
                    diff      = 32'(rd_size) - 32'(rq_reg);
                    if (diff >= 32'd2)
                    begin
                        total_next = total_reg + SW'(1);
                        mem_wdata  = pack_hdr(SW'(rq_reg), 1'b1, rd_link, 1'b0);
                        nu         = 32'(cur_reg) + 32'(rq_reg);
                        if (nu < HEAP_UNITS)
                        begin
                            run_next      = UW'(nu);
                            run_size_next = SW'(diff);
                            state_next    = S_HSPLIT;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        mem_wdata  = pack_hdr(rd_size, 1'b1, rd_link, 1'b0);
                        state_next = S_DONE;
                    end
                end
            end

            // Remainder of a split goes back on its list
            S_HSPLIT:
            begin
                push_en    = 1'b1;
                push_unit  = run_reg;
                push_size  = run_size_reg;
                state_next = S_DONE;
            end

            // Grow the heap end
            S_GROW:
            begin
                ne = 32'(heap_end_reg) + 32'(rq_reg);
                if ((ne <= 32'(limit_reg)) && (ne <= HEAP_UNITS))
                begin
                    mem_we        = 1'b1;
                    mem_waddr     = UW'(heap_end_reg);
                    mem_wdata     = pack_hdr(SW'(rq_reg), 1'b1, '0, 1'b0);
                    got_next      = UW'(heap_end_reg);
                    heap_end_next = SW'(ne);
                    total_next    = total_reg + SW'(1);
                    ok_next       = 1'b1;
                end
                else
                begin
                    ok_next = 1'b0;
                end
                state_next = S_DONE;
            end

            // Free: walk the heap up to the target block
            S_FRD:
            begin
                if (32'(u_reg) < 32'(target_reg))
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = u_reg[UW-1:0];
                    state_next = S_FCHK;
                end
                else if (32'(u_reg) == 32'(target_reg))
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = UW'(target_reg);
                    state_next = S_FFIN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_FCHK:
            begin
                if (rd_size == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    u_next     = u_reg + PW'(rd_size);
                    state_next = S_FRD;
                end
            end

            S_FFIN:
            begin
                if (rd_alloc)
                begin
                    push_en   = 1'b1;
                    push_unit = UW'(target_reg);
                    push_size = rd_size;
                    ok_next   = 1'b1;
                end
                state_next = S_DONE;
            end

            // Hand the result word to the output register
            S_DONE:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    pa              = (32'(got_reg) + 32'd1) << 4;
                    res_valid_next  = 1'b1;
                    res_ok_next     = ok_reg;
                    res_merged_next = merged_reg;
                    res_addr_next   = (ok_reg && !is_free_reg) ? pa[ADDR_W-1:0] : '0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Push a block onto the head of its class list
        if (push_en)
        begin
            pc         = class_of(CW'(push_size));
            mem_we     = 1'b1;
            mem_waddr  = push_unit;
            mem_wdata  = pack_hdr(push_size, 1'b0,
                                  valid_next[pc] ? heads_next[pc] : '0, !valid_next[pc]);
            heads_next[pc] = push_unit;
            valid_next[pc] = 1'b1;
            free_next      = free_next + SW'(1);
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                heads_reg[i] <= '0;
            end
            valid_reg      <= '0;
            heap_end_reg   <= '0;
            total_reg      <= '0;
            free_reg       <= '0;
            open_reg       <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            heads_reg      <= heads_next;
            valid_reg      <= valid_next;
            heap_end_reg   <= heap_end_next;
            total_reg      <= total_next;
            free_reg       <= free_next;
            open_reg       <= open_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        rq_reg         <= rq_next;
        cls_reg        <= cls_next;
        hcls_reg       <= hcls_next;
        u_reg          <= u_next;
        run_reg        <= run_next;
        run_size_reg   <= run_size_next;
        cur_reg        <= cur_next;
        prev_hdr_reg   <= prev_hdr_next;
        prev_reg       <= prev_next;
        has_prev_reg   <= has_prev_next;
        guard_reg      <= guard_next;
        hdr_reg        <= hdr_next;
        got_reg        <= got_next;
        target_reg     <= target_next;
        ok_reg         <= ok_next;
        merged_reg     <= merged_next;
        is_free_reg    <= is_free_next;
        res_addr_reg   <= res_addr_next;
        res_ok_reg     <= res_ok_next;
        res_merged_reg <= res_merged_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmin_reg  <= CMIN_RESET;
            shift_reg <= SHIFT_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COALESCE_MIN: cmin_reg  <= cfg_data[CMIN_W-1:0];
                CFG_FREE_SHIFT:   shift_reg <= cfg_data[SHIFT_W-1:0];
                CFG_HEAP_LIMIT:   limit_reg <= cfg_data[LIMIT_W-1:0];
                default:          ;
            endcase
        end
    end

endmodule

### design/sfa_hdr_mem.sv
// Block header store: one write port, one read port, registered read data.
// No dependencies.
module sfa_hdr_mem #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 27,
    parameter int AW    = 12
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
